// ===== design/fxa_pkg.sv =====
// Shared types and constants of the signed fixed-point ALU.
// Depends on nothing; the interfaces, the top level and the checker use it.
package fxa_pkg;

	localparam int FRAC_BITS_DEF  = 8;
	localparam int WORD_WIDTH_DEF = 32;
	localparam int PORT_WIDTH     = 32;

	typedef enum logic [3:0] {
		OP_ADD      = 4'd0,
		OP_SUB      = 4'd1,
		OP_MUL      = 4'd2,
		OP_DIV      = 4'd3,
		OP_GT       = 4'd4,
		OP_LT       = 4'd5,
		OP_GE       = 4'd6,
		OP_LE       = 4'd7,
		OP_EQ       = 4'd8,
		OP_NE       = 4'd9,
		OP_MIN      = 4'd10,
		OP_MAX      = 4'd11,
		OP_INC      = 4'd12,
		OP_DEC      = 4'd13,
		OP_FROM_INT = 4'd14,
		OP_TO_INT   = 4'd15
	} op_t;

	typedef struct packed {
		logic [3:0]                   operation;
		logic signed [PORT_WIDTH-1:0] operand_a;
		logic signed [PORT_WIDTH-1:0] operand_b;
	} cmd_t;

	typedef struct packed {
		logic signed [PORT_WIDTH-1:0] result_word;
		logic                         compare_true;
		logic                         divide_by_zero;
	} res_t;

endpackage

// ===== design/fxa_cmd_if.sv =====
// Valid/ready channel that carries one ALU command per beat.
// Depends on fxa_pkg.
interface fxa_cmd_if;
	logic          valid;
	logic          ready;
	fxa_pkg::cmd_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ===== design/fxa_res_if.sv =====
// Valid/ready channel that carries one ALU result per beat.
// Depends on fxa_pkg.
interface fxa_res_if;
	logic          valid;
	logic          ready;
	fxa_pkg::res_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ===== design/fxa_div_pipe.sv =====
// Pipelined restoring divider of unsigned magnitudes, one quotient bit per stage.
// Self-contained; instantiated by fixed_point_alu_q24_8.
module fxa_div_pipe #(
	parameter int DVD_WIDTH = 40,
	parameter int DVS_WIDTH = 32
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic [DVD_WIDTH-1:0] dividend,
	input  logic [DVS_WIDTH-1:0] divisor,
	output logic [DVD_WIDTH-1:0] quotient
);

	// Each stage holds the partial remainder and a word that shifts the
	// remaining dividend bits out at the top while quotient bits enter below.
	logic [DVS_WIDTH-1:0] rem_s [DVD_WIDTH];
	logic [DVD_WIDTH-1:0] nq_s  [DVD_WIDTH];
	logic [DVS_WIDTH-1:0] dvs_s [DVD_WIDTH];

	for (genvar i = 0; i < DVD_WIDTH; i++) begin : g_stage
		logic [DVS_WIDTH-1:0] rem_in;
		logic [DVD_WIDTH-1:0] nq_in;
		logic [DVS_WIDTH-1:0] dvs_in;
		logic [DVS_WIDTH:0]   trial;
		logic [DVS_WIDTH:0]   diff;
		logic                 fits;

		if (i == 0) begin : g_first
			assign rem_in = '0;
			assign nq_in  = dividend;
			assign dvs_in = divisor;
		end else begin : g_next
			assign rem_in = rem_s[i-1];
			assign nq_in  = nq_s[i-1];
			assign dvs_in = dvs_s[i-1];
		end

		assign trial = {rem_in, nq_in[DVD_WIDTH-1]};
		assign diff  = trial - {1'b0, dvs_in};
		assign fits  = trial >= {1'b0, dvs_in};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i] <= fits ? diff[DVS_WIDTH-1:0] : trial[DVS_WIDTH-1:0];
				nq_s[i]  <= {nq_in[DVD_WIDTH-2:0], fits};
				dvs_s[i] <= dvs_in;
			end
		end
	end

	assign quotient = nq_s[DVD_WIDTH-1];

endmodule

// ===== design/fixed_point_alu_q24_8.sv =====
// Signed fixed-point ALU, Q(WORD_WIDTH-FRAC_BITS).FRAC_BITS, fully pipelined.
// The default is Q24.8. Every operation takes the divider path, which resolves
// one quotient bit per stage, between stage 2 and the output register.
// Throughput is one beat per cycle; a stalled output freezes the whole pipe.
// Reset clears all valid bits at once; the data registers are not reset.
module fixed_point_alu_q24_8 #(
	parameter int FRAC_BITS  = fxa_pkg::FRAC_BITS_DEF,
	parameter int WORD_WIDTH = fxa_pkg::WORD_WIDTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	fxa_cmd_if.sink       cmd,
	fxa_res_if.source     res
);

	localparam int W  = WORD_WIDTH;
	localparam int DW = WORD_WIDTH + FRAC_BITS;
	localparam int PW = 2 * WORD_WIDTH + FRAC_BITS;

	typedef struct packed {
		logic [W-1:0] word;
		logic         cmp;
		logic         is_div;
		logic         dz;
		logic         neg;
	} side_t;

	logic en;
	assign en        = !res.valid || res.ready;
	assign cmd.ready = en;

	// Stage 1: operands wrapped to the word width.
	logic                v_s1;
	fxa_pkg::op_t        op_s1;
	logic signed [W-1:0] a_s1, b_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s1 <= fxa_pkg::op_t'(cmd.data.operation);
			a_s1  <= W'(cmd.data.operand_a);
			b_s1  <= W'(cmd.data.operand_b);
		end
	end

	// Stage 2: simple operations, the product and the divider operands.
	logic signed [W-1:0]  simple;
	logic                 cmp;
	logic signed [PW-1:0] prod;
	logic [W-1:0]         mag_a, mag_b;

	assign prod  = PW'(a_s1) * PW'(b_s1);
	assign mag_a = a_s1[W-1] ? W'(-a_s1) : a_s1;
	assign mag_b = b_s1[W-1] ? W'(-b_s1) : b_s1;

	always_comb begin
		simple = '0;
		cmp    = 1'b0;
		case (op_s1)
			fxa_pkg::OP_ADD:      simple = a_s1 + b_s1;
			fxa_pkg::OP_SUB:      simple = a_s1 - b_s1;
			fxa_pkg::OP_GT:       cmp = a_s1 > b_s1;
			fxa_pkg::OP_LT:       cmp = a_s1 < b_s1;
			fxa_pkg::OP_GE:       cmp = a_s1 >= b_s1;
			fxa_pkg::OP_LE:       cmp = a_s1 <= b_s1;
			fxa_pkg::OP_EQ:       cmp = a_s1 == b_s1;
			fxa_pkg::OP_NE:       cmp = a_s1 != b_s1;
			fxa_pkg::OP_MIN:      simple = (a_s1 < b_s1) ? a_s1 : b_s1;
			fxa_pkg::OP_MAX:      simple = (a_s1 > b_s1) ? a_s1 : b_s1;
			fxa_pkg::OP_INC:      simple = a_s1 + W'(1);
			fxa_pkg::OP_DEC:      simple = a_s1 - W'(1);
			fxa_pkg::OP_FROM_INT: simple = a_s1 <<< FRAC_BITS;
			fxa_pkg::OP_TO_INT:   simple = a_s1 >>> FRAC_BITS;
			default:              simple = '0;
		endcase
	end

	logic          v_s2;
	logic [W-1:0]  simple_s2, prod_s2;
	logic          cmp_s2, is_mul_s2, is_div_s2, dz_s2, neg_s2;
	logic [DW-1:0] dvd_s2;
	logic [W-1:0]  dvs_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			simple_s2 <= simple;
			prod_s2   <= prod[FRAC_BITS+W-1:FRAC_BITS];
			cmp_s2    <= cmp;
			is_mul_s2 <= op_s1 == fxa_pkg::OP_MUL;
			is_div_s2 <= op_s1 == fxa_pkg::OP_DIV;
			dz_s2     <= (op_s1 == fxa_pkg::OP_DIV) && (b_s1 == '0);
			neg_s2    <= a_s1[W-1] ^ b_s1[W-1];
			dvd_s2    <= DW'(mag_a) << FRAC_BITS;
			dvs_s2    <= mag_b;
		end
	end

	// Divider stages, with the other results riding alongside.
	logic [DW-1:0] quot;

	fxa_div_pipe #(
		.DVD_WIDTH(DW),
		.DVS_WIDTH(W)
	) u_div (
		.clk     (clk),
		.en      (en),
		.dividend(dvd_s2),
		.divisor (dvs_s2),
		.quotient(quot)
	);

	logic  v_dl [DW];
	side_t side_dl [DW];
	side_t side_in;

	assign side_in = '{
		word:   is_mul_s2 ? prod_s2 : simple_s2,
		cmp:    cmp_s2,
		is_div: is_div_s2,
		dz:     dz_s2,
		neg:    neg_s2
	};

	for (genvar i = 0; i < DW; i++) begin : g_dl
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_dl[i] <= 1'b0;
			end else if (en) begin
				v_dl[i] <= (i == 0) ? v_s2 : v_dl[(i == 0) ? 0 : i-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_dl[i] <= (i == 0) ? side_in : side_dl[(i == 0) ? 0 : i-1];
			end
		end
	end

	// Output register: sign the quotient and pick the result.
	side_t        last;
	logic [W-1:0] qw, div_word;

	assign last     = side_dl[DW-1];
	assign qw       = quot[W-1:0];
	assign div_word = last.dz ? '0 : (last.neg ? W'(-qw) : qw);

	logic                v_out_q;
	logic signed [W-1:0] word_q;
	logic                cmp_q, dz_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_out_q <= 1'b0;
		end else if (en) begin
			v_out_q <= v_dl[DW-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			word_q <= last.is_div ? div_word : last.word;
			cmp_q  <= last.cmp;
			dz_q   <= last.dz;
		end
	end

	assign res.valid               = v_out_q;
	assign res.data.result_word    = fxa_pkg::PORT_WIDTH'(word_q);
	assign res.data.compare_true   = cmp_q;
	assign res.data.divide_by_zero = dz_q;

endmodule

// ===== design/fxa_checker.sv =====
// Port-level assertions for the fixed-point ALU, bound to its top level.
// Depends on fxa_pkg and fixed_point_alu_q24_8.
module fxa_checker (
	input logic                                   clk,
	input logic                                   arst_n,
	input logic                                   cmd_valid,
	input logic                                   cmd_ready,
	input logic                                   res_valid,
	input logic                                   res_ready,
	input logic signed [fxa_pkg::PORT_WIDTH-1:0]  result_word,
	input logic                                   compare_true,
	input logic                                   divide_by_zero
);

	// The pipe moves whenever the output register is free or being drained.
	a_ready_follows_output: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_ready == (!res_valid || res_ready))
		else $error("input ready does not track the output stage");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(compare_true && divide_by_zero))
		else $error("compare and divide-by-zero flags both set");

	a_dz_zero_result: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && divide_by_zero) |-> (result_word == '0))
		else $error("division by zero returned a nonzero word");

	a_cmp_zero_result: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && compare_true) |-> (result_word == '0))
		else $error("comparison returned a nonzero word");

	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |=> (res_valid && $stable(result_word)))
		else $error("stalled result beat changed or vanished");

endmodule

bind fixed_point_alu_q24_8 fxa_checker u_fxa_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.cmd_valid     (cmd.valid),
	.cmd_ready     (cmd.ready),
	.res_valid     (res.valid),
	.res_ready     (res.ready),
	.result_word   (res.data.result_word),
	.compare_true  (res.data.compare_true),
	.divide_by_zero(res.data.divide_by_zero)
);
